// File: rtl/mrc_pkg.sv
`timescale 1ns / 1ps

package mrc_pkg;

   localparam int COORD_BITS  = 11;
   localparam int RADIUS_BITS = 10;
   localparam int POINT_BITS  = COORD_BITS + 2;
   // The iterator x runs from radius-1 down and may reach -1, so it carries a sign bit.
   localparam int X_BITS      = RADIUS_BITS + 2;
   localparam int Y_BITS      = RADIUS_BITS + 1;
   localparam int STEP_BITS   = RADIUS_BITS + 2;
   localparam int ERR_BITS    = RADIUS_BITS + 3;
   localparam int OCT_BITS    = 3;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic {
      OP_START = 1'b0,
      OP_NEXT  = 1'b1
   } op_type;

   // One classified item: either a point set for the current (x, y) or a finished marker.
   typedef struct packed {
      logic                       fin;
      logic [COORD_BITS-1:0]      cx;
      logic [COORD_BITS-1:0]      cy;
      logic signed [X_BITS-1:0]   x;
      logic [Y_BITS-1:0]          y;
   } job_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

endpackage

// File: rtl/mrc_req_if.sv
`timescale 1ns / 1ps

interface mrc_req_if import mrc_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic                   operation;
   logic [COORD_BITS-1:0]  center_x;
   logic [COORD_BITS-1:0]  center_y;
   logic [RADIUS_BITS-1:0] radius;

   modport source (output valid, output operation, output center_x, output center_y,
                   output radius, input ready);
   modport sink   (input valid, input operation, input center_x, input center_y,
                   input radius, output ready);
endinterface

// File: rtl/mrc_rsp_if.sv
`timescale 1ns / 1ps

interface mrc_rsp_if import mrc_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic signed [POINT_BITS-1:0] point_x;
   logic signed [POINT_BITS-1:0] point_y;
   logic                         point_valid;
   logic                         last_of_step;
   logic                         finished;

   modport source (output valid, output point_x, output point_y, output point_valid,
                   output last_of_step, output finished, input ready);
   modport sink   (input valid, input point_x, input point_y, input point_valid,
                   input last_of_step, input finished, output ready);
endinterface

// File: rtl/mrc_front.sv
`timescale 1ns / 1ps

module mrc_front import mrc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   mrc_req_if.sink          req_chan,
   input  queue_status_type q_status,
   output logic             push,
   output job_type          push_job
);

   logic                          circle_active_ff, circle_active_in;
   logic [COORD_BITS-1:0]         held_cx_ff, held_cx_in;
   logic [COORD_BITS-1:0]         held_cy_ff, held_cy_in;
   logic [RADIUS_BITS-1:0]        held_radius_ff, held_radius_in;
   logic signed [X_BITS-1:0]      octant_x_ff, octant_x_in;
   logic [Y_BITS-1:0]             octant_y_ff, octant_y_in;
   logic [STEP_BITS-1:0]          step_dx_ff, step_dx_in;
   logic [STEP_BITS-1:0]          step_dy_ff, step_dy_in;
   logic [ERR_BITS-1:0]           error_ff, error_in;

   logic                          start;
   logic                          act_eff;
   logic signed [X_BITS-1:0]      x_eff, x_upd;
   logic [Y_BITS-1:0]             y_eff, y_upd;
   logic [STEP_BITS-1:0]          dx_eff, dx_upd, dy_eff, dy_upd;
   logic [ERR_BITS-1:0]           err_eff, err_mid, err_upd;
   logic [ERR_BITS-1:0]           two_r;
   logic                          done;

   assign req_chan.ready = !q_status.full;
   assign push           = req_chan.valid && req_chan.ready;
   assign start          = (op_type'(req_chan.operation) == OP_START);

   always_comb begin
      // A start item loads the iterator first; the point set then comes from the loaded values.
      if (start) begin
         held_cx_in     = req_chan.center_x;
         held_cy_in     = req_chan.center_y;
         held_radius_in = req_chan.radius;
         act_eff        = 1'b1;
         x_eff          = X_BITS'(req_chan.radius) - X_BITS'(1);
         y_eff          = '0;
         dx_eff         = STEP_BITS'(1);
         dy_eff         = STEP_BITS'(1);
         err_eff        = ERR_BITS'(1) - ERR_BITS'({req_chan.radius, 1'b0});
      end else begin
         held_cx_in     = held_cx_ff;
         held_cy_in     = held_cy_ff;
         held_radius_in = held_radius_ff;
         act_eff        = circle_active_ff;
         x_eff          = octant_x_ff;
         y_eff          = octant_y_ff;
         dx_eff         = step_dx_ff;
         dy_eff         = step_dy_ff;
         err_eff        = error_ff;
      end

      done  = !act_eff || (x_eff < $signed({1'b0, y_eff}));
      two_r = ERR_BITS'({held_radius_in, 1'b0});

      y_upd   = y_eff;
      dy_upd  = dy_eff;
      err_mid = err_eff;
      if ($signed(err_eff) <= 0) begin
         y_upd   = y_eff + Y_BITS'(1);
         dy_upd  = dy_eff + STEP_BITS'(2);
         err_mid = err_eff + ERR_BITS'(dy_eff);
      end

      x_upd   = x_eff;
      dx_upd  = dx_eff;
      err_upd = err_mid;
      if ($signed(err_mid) > 0) begin
         x_upd   = x_eff - X_BITS'(1);
         dx_upd  = dx_eff + STEP_BITS'(2);
         err_upd = err_mid + ERR_BITS'(dx_eff + STEP_BITS'(2)) - two_r;
      end

      circle_active_in = !done;
      if (done) begin
         octant_x_in = x_eff;
         octant_y_in = y_eff;
         step_dx_in  = dx_eff;
         step_dy_in  = dy_eff;
         error_in    = err_eff;
      end else begin
         octant_x_in = x_upd;
         octant_y_in = y_upd;
         step_dx_in  = dx_upd;
         step_dy_in  = dy_upd;
         error_in    = err_upd;
      end

      push_job.fin = done;
      push_job.cx  = held_cx_in;
      push_job.cy  = held_cy_in;
      push_job.x   = x_eff;
      push_job.y   = y_eff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         circle_active_ff <= 1'b0;
      end else if (push) begin
         circle_active_ff <= circle_active_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         held_cx_ff     <= held_cx_in;
         held_cy_ff     <= held_cy_in;
         held_radius_ff <= held_radius_in;
         octant_x_ff    <= octant_x_in;
         octant_y_ff    <= octant_y_in;
         step_dx_ff     <= step_dx_in;
         step_dy_ff     <= step_dy_in;
         error_ff       <= error_in;
      end
   end

endmodule

// File: rtl/mrc_queue.sv
`timescale 1ns / 1ps

module mrc_queue import mrc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  job_type          push_job,
   input  logic             pop,
   output job_type          head_job,
   output queue_status_type q_status
);

   job_type                entries_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_BITS-1:0]   count_ff;

   assign q_status.empty = (count_ff == '0);
   assign q_status.full  = (count_ff == QCNT_BITS'(QUEUE_DEPTH));
   assign head_job       = entries_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_BITS'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_BITS'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + QCNT_BITS'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - QCNT_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// File: rtl/mrc_back.sv
`timescale 1ns / 1ps

module mrc_back import mrc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  job_type          head_job,
   input  queue_status_type q_status,
   output logic             pop,
   mrc_rsp_if.source        rsp_chan
);

   logic                         rsp_valid_ff;
   logic signed [POINT_BITS-1:0] point_x_ff, point_x_in;
   logic signed [POINT_BITS-1:0] point_y_ff, point_y_in;
   logic                         point_valid_ff, point_valid_in;
   logic                         last_ff, last_in;
   logic                         finished_ff, finished_in;
   logic [OCT_BITS-1:0]          oct_ff;

   logic                         out_load, fire;
   logic                         swap, neg_x, neg_y;
   logic signed [POINT_BITS-1:0] xs, ys, cxs, cys, a_val, b_val;

   assign out_load = !rsp_valid_ff || rsp_chan.ready;
   assign fire     = out_load && !q_status.empty;
   assign pop      = fire && last_in;

   always_comb begin
      // Octant order: (+x,+y) (+y,+x) (-y,+x) (-x,+y) (-x,-y) (-y,-x) (+y,-x) (+x,-y).
      swap  = (oct_ff == 3'd1) || (oct_ff == 3'd2) || (oct_ff == 3'd5) || (oct_ff == 3'd6);
      neg_x = (oct_ff == 3'd2) || (oct_ff == 3'd3) || (oct_ff == 3'd4) || (oct_ff == 3'd5);
      neg_y = oct_ff[2];

      xs    = POINT_BITS'(head_job.x);
      ys    = POINT_BITS'({1'b0, head_job.y});
      cxs   = POINT_BITS'({1'b0, head_job.cx});
      cys   = POINT_BITS'({1'b0, head_job.cy});
      a_val = swap ? ys : xs;
      b_val = swap ? xs : ys;

      if (head_job.fin) begin
         point_x_in     = '0;
         point_y_in     = '0;
         point_valid_in = 1'b0;
         last_in        = 1'b1;
         finished_in    = 1'b1;
      end else begin
         point_x_in     = neg_x ? (cxs - a_val) : (cxs + a_val);
         point_y_in     = neg_y ? (cys - b_val) : (cys + b_val);
         point_valid_in = 1'b1;
         last_in        = &oct_ff;
         finished_in    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         oct_ff       <= '0;
      end else begin
         if (out_load) begin
            rsp_valid_ff <= !q_status.empty;
         end
         if (fire) begin
            oct_ff <= last_in ? '0 : oct_ff + OCT_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         point_x_ff     <= point_x_in;
         point_y_ff     <= point_y_in;
         point_valid_ff <= point_valid_in;
         last_ff        <= last_in;
         finished_ff    <= finished_in;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.point_x      = point_x_ff;
   assign rsp_chan.point_y      = point_y_ff;
   assign rsp_chan.point_valid  = point_valid_ff;
   assign rsp_chan.last_of_step = last_ff;
   assign rsp_chan.finished     = finished_ff;

endmodule

// File: rtl/midpoint_circle_rasterizer.sv
`timescale 1ns / 1ps
// Midpoint circle point generator.
// The req_chan channel takes start items (operation 0, with center and radius) and
// next items (operation 1). Each item returns eight mirrored points of the current
// octant position on rsp_chan, the eighth flagged last_of_step, or one finished
// marker (no point, last_of_step and finished set) once the circle is complete or
// when no circle is in progress.
// The front stage updates the iterator as it accepts an item and puts the classified
// item in a two-entry queue. The back stage expands one queued item into results,
// one result per cycle while rsp_chan accepts them, into a registered output.
// An item passes through the queue and then the output register before its first result.
// A point-bearing item gives eight results and a finished marker gives one; the single
// output register takes one result per cycle when rsp_chan is not stalled.
// When rsp_chan stalls, the output register holds its result, the back stage waits,
// and req_chan keeps accepting until the queue is full.
// Reset is synchronous and active high: the queue and output empty, no circle is active.
module midpoint_circle_rasterizer import mrc_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   mrc_req_if.sink   req_chan,
   mrc_rsp_if.source rsp_chan
);

   logic             push, pop;
   job_type          push_job, head_job;
   queue_status_type q_status;

   mrc_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_status (q_status),
      .push     (push),
      .push_job (push_job)
   );

   mrc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .q_status (q_status)
   );

   mrc_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head_job (head_job),
      .q_status (q_status),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

endmodule

// File: tb/tb_midpoint_circle_rasterizer.sv
`timescale 1ns / 1ps

module tb_midpoint_circle_rasterizer import mrc_pkg::*; ();

   localparam int CYCLE_LIMIT   = 400000;
   localparam int RANDOM_ITEMS  = 300;
   localparam int HOLD_AFTER    = 600;
   localparam int HOLD_CYCLES   = 300;
   localparam int DRAIN_CYCLES  = 20;
   localparam int DIRECTED_ROWS = 25;

   typedef struct packed {
      logic [POINT_BITS-1:0] point_x;
      logic [POINT_BITS-1:0] point_y;
      logic                  point_valid;
      logic                  last_of_step;
      logic                  finished;
   } plot_result_type;

   typedef struct {
      op_type                 op;
      logic [COORD_BITS-1:0]  cx;
      logic [COORD_BITS-1:0]  cy;
      logic [RADIUS_BITS-1:0] r;
      bit                     typed;
      plot_result_type        rsp;
   } stim_row_type;

   localparam plot_result_type FIN_MARK = '{point_x: '0, point_y: '0, point_valid: 1'b0,
                                            last_of_step: 1'b1, finished: 1'b1};

   // Rows marked typed carry their expected finished marker; the rest go through the predictor.
   stim_row_type directed_rows [DIRECTED_ROWS] = '{
      '{OP_NEXT,  11'd0,    11'd0,    10'd0,    1'b1, FIN_MARK},
      '{OP_NEXT,  11'd2047, 11'd2047, 10'd1023, 1'b1, FIN_MARK},
      '{OP_START, 11'd2047, 11'd2047, 10'd0,    1'b1, FIN_MARK},
      '{OP_NEXT,  11'd0,    11'd0,    10'd0,    1'b1, FIN_MARK},
      '{OP_START, 11'd0,    11'd0,    10'd1,    1'b0, FIN_MARK},
      '{OP_NEXT,  11'd0,    11'd0,    10'd0,    1'b0, FIN_MARK},
      '{OP_NEXT,  11'd2047, 11'd0,    10'd1023, 1'b1, FIN_MARK},
      '{OP_START, 11'd0,    11'd0,    10'd1023, 1'b0, FIN_MARK},
      '{OP_NEXT,  11'd1365, 11'd682,  10'd341,  1'b0, FIN_MARK},
      '{OP_NEXT,  11'd682,  11'd1365, 10'd682,  1'b0, FIN_MARK},
      '{OP_START, 11'd2047, 11'd2047, 10'd1023, 1'b0, FIN_MARK},
      '{OP_NEXT,  11'd0,    11'd0,    10'd0,    1'b0, FIN_MARK},
      '{OP_START, 11'd2047, 11'd0,    10'd1023, 1'b0, FIN_MARK},
      '{OP_START, 11'd0,    11'd2047, 10'd1023, 1'b0, FIN_MARK},
      '{OP_NEXT,  11'd2047, 11'd2047, 10'd1023, 1'b0, FIN_MARK},
      '{OP_START, 11'd682,  11'd1365, 10'd682,  1'b0, FIN_MARK},
      '{OP_START, 11'd1024, 11'd1024, 10'd2,    1'b0, FIN_MARK},
      '{OP_NEXT,  11'd0,    11'd0,    10'd0,    1'b0, FIN_MARK},
      '{OP_NEXT,  11'd0,    11'd0,    10'd0,    1'b0, FIN_MARK},
      '{OP_NEXT,  11'd0,    11'd0,    10'd0,    1'b0, FIN_MARK},
      '{OP_NEXT,  11'd0,    11'd0,    10'd0,    1'b0, FIN_MARK},
      '{OP_START, 11'd100,  11'd5,    10'd3,    1'b0, FIN_MARK},
      '{OP_NEXT,  11'd0,    11'd0,    10'd0,    1'b0, FIN_MARK},
      '{OP_START, 11'd0,    11'd0,    10'd0,    1'b1, FIN_MARK},
      '{OP_NEXT,  11'd0,    11'd0,    10'd0,    1'b1, FIN_MARK}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   mrc_req_if req_chan ();
   mrc_rsp_if rsp_chan ();

   midpoint_circle_rasterizer dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Predictor copy of the circle iterator.
   int                     circ_x      = 0;
   int                     circ_y      = 0;
   int                     circ_dx     = 1;
   int                     circ_dy     = 1;
   int                     circ_err    = 0;
   logic [COORD_BITS-1:0]  circ_cx     = '0;
   logic [COORD_BITS-1:0]  circ_cy     = '0;
   logic [RADIUS_BITS-1:0] circ_r      = '0;
   bit                     circ_active = 1'b0;

   plot_result_type expected_points[$];
   int         errors_seen   = 0;
   int         results_seen  = 0;
   int         cycle_count   = 0;
   int         send_burst    = 0;
   int         recv_burst    = 0;
   int         next_gap      = 0;
   bit         last_done     = 1'b0;

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_midpoint_circle_rasterizer: FAIL");
         $finish;
      end
   end

   // Idle cycles before the next transfer; now and then a burst of items with no idling.
   function automatic int idle_cycles(ref int burst_left);
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      if ($urandom_range(0, 19) == 0) burst_left = $urandom_range(10, 40);
      return $urandom_range(0, 13);
   endfunction

   function automatic void queue_point(int px, int py, bit last);
      plot_result_type p;
      p.point_x      = px[POINT_BITS-1:0];
      p.point_y      = py[POINT_BITS-1:0];
      p.point_valid  = 1'b1;
      p.last_of_step = last;
      p.finished     = 1'b0;
      expected_points.push_back(p);
   endfunction

   task automatic rasterize_step(input op_type op, input logic [COORD_BITS-1:0] cx_in,
                                 input logic [COORD_BITS-1:0] cy_in,
                                 input logic [RADIUS_BITS-1:0] r_in, input bit keep,
                                 output bit done);
      int cx;
      int cy;
      if (op == OP_START) begin
         circ_cx     = cx_in;
         circ_cy     = cy_in;
         circ_r      = r_in;
         circ_x      = int'(r_in) - 1;
         circ_y      = 0;
         circ_dx     = 1;
         circ_dy     = 1;
         circ_err    = 1 - 2 * int'(r_in);
         circ_active = 1'b1;
      end
      done = !circ_active || circ_x < circ_y;
      if (done) begin
         circ_active = 1'b0;
         if (keep) expected_points.push_back(FIN_MARK);
         return;
      end
      cx = int'(circ_cx);
      cy = int'(circ_cy);
      if (keep) begin
         queue_point(cx + circ_x, cy + circ_y, 1'b0);
         queue_point(cx + circ_y, cy + circ_x, 1'b0);
         queue_point(cx - circ_y, cy + circ_x, 1'b0);
         queue_point(cx - circ_x, cy + circ_y, 1'b0);
         queue_point(cx - circ_x, cy - circ_y, 1'b0);
         queue_point(cx - circ_y, cy - circ_x, 1'b0);
         queue_point(cx + circ_y, cy - circ_x, 1'b0);
         queue_point(cx + circ_x, cy - circ_y, 1'b1);
      end
      if (circ_err <= 0) begin
         circ_y   += 1;
         circ_err += circ_dy;
         circ_dy  += 2;
      end
      // The second test sees the error as updated by the first.
      if (circ_err > 0) begin
         circ_x   -= 1;
         circ_dx  += 2;
         circ_err += circ_dx - 2 * int'(circ_r);
      end
   endtask

   task automatic send_item(input stim_row_type row);
      bit done;
      repeat (next_gap) @(posedge clock);
      req_chan.valid     <= 1'b1;
      req_chan.operation <= row.op;
      req_chan.center_x  <= row.cx;
      req_chan.center_y  <= row.cy;
      req_chan.radius    <= row.r;
      do @(posedge clock); while (!req_chan.ready);
      rasterize_step(row.op, row.cx, row.cy, row.r, !row.typed, done);
      if (row.typed) expected_points.push_back(row.rsp);
      last_done = done;
      // Valid stays up only when the next item follows at once.
      next_gap = idle_cycles(send_burst);
      if (next_gap > 0) req_chan.valid <= 1'b0;
   endtask

   task automatic quiesce();
      if (next_gap == 0) begin
         req_chan.valid <= 1'b0;
         next_gap = 1;
      end
      while (expected_points.size() != 0) @(posedge clock);
   endtask

   function automatic stim_row_type random_row(op_type op, logic [RADIUS_BITS-1:0] r);
      stim_row_type row;
      row.op    = op;
      row.cx    = COORD_BITS'($urandom_range(0, 2047));
      row.cy    = COORD_BITS'($urandom_range(0, 2047));
      row.r     = r;
      row.typed = 1'b0;
      row.rsp   = FIN_MARK;
      return row;
   endfunction

   initial begin : rsp_side
      plot_result_type want;
      int         gap;
      bit         held_off;
      held_off = 1'b0;
      rsp_chan.ready <= 1'b0;
      @(negedge reset);
      forever begin
         // One long hold-off so the block fills its queue and stalls its input.
         if (!held_off && results_seen >= HOLD_AFTER) begin
            held_off = 1'b1;
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         gap = idle_cycles(recv_burst);
         if (gap > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
         results_seen++;
         if (expected_points.size() == 0) begin
            $error("unexpected result: point_x %0d point_y %0d finished %0b",
                   $signed(rsp_chan.point_x), $signed(rsp_chan.point_y), rsp_chan.finished);
            errors_seen++;
         end else begin
            want = expected_points.pop_front();
            if (rsp_chan.point_x !== want.point_x) begin
               $error("point_x: expected %0d, got %0d", $signed(want.point_x),
                      $signed(rsp_chan.point_x));
               errors_seen++;
            end
            if (rsp_chan.point_y !== want.point_y) begin
               $error("point_y: expected %0d, got %0d", $signed(want.point_y),
                      $signed(rsp_chan.point_y));
               errors_seen++;
            end
            if (rsp_chan.point_valid !== want.point_valid) begin
               $error("point_valid: expected %0b, got %0b", want.point_valid,
                      rsp_chan.point_valid);
               errors_seen++;
            end
            if (rsp_chan.last_of_step !== want.last_of_step) begin
               $error("last_of_step: expected %0b, got %0b", want.last_of_step,
                      rsp_chan.last_of_step);
               errors_seen++;
            end
            if (rsp_chan.finished !== want.finished) begin
               $error("finished: expected %0b, got %0b", want.finished, rsp_chan.finished);
               errors_seen++;
            end
         end
      end
   end

   initial begin : req_side
      int                     random_items;
      int                     max_next;
      int                     k;
      bit                     paused;
      logic [RADIUS_BITS-1:0] r;
      random_items = 0;
      paused       = 1'b0;
      req_chan.valid     <= 1'b0;
      req_chan.operation <= OP_START;
      req_chan.center_x  <= '0;
      req_chan.center_y  <= '0;
      req_chan.radius    <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_ROWS; i++) send_item(directed_rows[i]);

      // Mostly whole circles of small radius walked to completion; some cut short or
      // restarted, some with a radius anywhere in range, and stray steps after the end.
      while (random_items < RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            0:       r = RADIUS_BITS'($urandom_range(0, 1023));
            1:       r = RADIUS_BITS'($urandom_range(13, 40));
            default: r = RADIUS_BITS'($urandom_range(0, 12));
         endcase
         send_item(random_row(OP_START, r));
         random_items++;
         if ($urandom_range(0, 9) == 0) max_next = $urandom_range(0, 5);
         else if (r <= 12) max_next = 64;
         else max_next = $urandom_range(1, 30);
         k = 0;
         while (!last_done && k < max_next) begin
            send_item(random_row(OP_NEXT, RADIUS_BITS'($urandom_range(0, 1023))));
            random_items++;
            k++;
         end
         if (last_done && $urandom_range(0, 3) == 0) begin
            send_item(random_row(OP_NEXT, RADIUS_BITS'($urandom_range(0, 1023))));
            random_items++;
         end
         if (!paused && random_items >= RANDOM_ITEMS / 2) begin
            paused = 1'b1;
            quiesce();
         end
      end

      quiesce();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors_seen == 0) begin
         $display("tb_midpoint_circle_rasterizer: PASS");
      end else begin
         $display("tb_midpoint_circle_rasterizer: FAIL");
      end
      $finish;
   end

endmodule

// File: midpoint_circle_rasterizer.f
rtl/mrc_pkg.sv
rtl/mrc_req_if.sv
rtl/mrc_rsp_if.sv
rtl/mrc_front.sv
rtl/mrc_queue.sv
rtl/mrc_back.sv
rtl/midpoint_circle_rasterizer.sv
tb/tb_midpoint_circle_rasterizer.sv
